// ===== hdl/pee_pkg.sv =====
// Package for the postfix expression evaluator: widths, character codes,
// status and operator codes, and the controller/datapath command structs.
// No dependencies.
package pee_pkg;

   localparam int DATA_W          = 32;
   localparam int SYM_W           = 8;
   localparam int STATUS_W        = 3;
   localparam int STACK_DEPTH_DEF = 64;
   localparam int DIV_CNT_W       = $clog2(DATA_W);

   localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;
   localparam logic [SYM_W-1:0] SYM_NINE  = 8'h39;
   localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
   localparam logic [SYM_W-1:0] SYM_STAR  = 8'h2A;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_UNDER   = 3'd1,
      ST_OVER    = 3'd2,
      ST_DIVZERO = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef struct packed {
      logic       latch;
      logic       push;
      logic       set_err;
      status_type err_code;
      logic       alu;
      logic       div_start;
      logic       div_write;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic   is_digit;
      op_type op;
      logic   full;
      logic   lt2;
      logic   err_set;
      logic   last;
      logic   right_zero;
      logic   div_done;
   } dp_status_type;

   function automatic logic is_digit(input logic [SYM_W-1:0] sym);
      return sym inside {[SYM_ZERO:SYM_NINE]};
   endfunction

   function automatic op_type decode_op(input logic [SYM_W-1:0] sym);
      op_type op;
      case (sym)
         SYM_PLUS:  op = OP_ADD;
         SYM_MINUS: op = OP_SUB;
         SYM_STAR:  op = OP_MUL;
         default:   op = OP_DIV;
      endcase
      return op;
   endfunction

endpackage

// ===== hdl/pee_stream_if.sv =====
// Valid/ready channel interfaces for the evaluator: character beats in,
// result beats out. Depends on pee_pkg.
interface pee_req_if
   import pee_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [SYM_W-1:0] symbol;
   logic             last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface pee_rsp_if
   import pee_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [DATA_W-1:0]   value;
   logic        [STATUS_W-1:0] status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== hdl/pee_div.sv =====
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating
// toward zero. Depends on pee_pkg.
module pee_div
   import pee_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] num,
   input  logic [DATA_W-1:0] den,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DATA_W-1:0]    rem_ff, rem_in;
   logic [DATA_W-1:0]    quo_ff, quo_in;
   logic [DATA_W-1:0]    den_ff, den_in;
   logic                 neg_ff, neg_in;
   logic [DATA_W:0]      trial;

   assign trial = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = num[DATA_W-1] ? (DATA_W'(0) - num) : num;
         den_in  = den[DATA_W-1] ? (DATA_W'(0) - den) : den;
         neg_in  = num[DATA_W-1] ^ den[DATA_W-1];
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DATA_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;

endmodule

// ===== hdl/pee_datapath.sv =====
// Evaluator datapath: top-of-stack register, operand stack memory, ALU,
// divider and result register. Depends on pee_pkg and pee_div.
module pee_datapath
   import pee_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
)(
   input  logic                       clock,
   input  logic                       reset,
   input  cmd_type                    cmd,
   output dp_status_type              st,
   input  logic [SYM_W-1:0]           req_symbol,
   input  logic                       req_last,
   output logic signed [DATA_W-1:0]   rsp_value,
   output logic        [STATUS_W-1:0] rsp_status
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic [DATA_W-1:0]   mem [STACK_DEPTH];
   logic [DATA_W-1:0]   rd_ff;
   logic [DATA_W-1:0]   tos_ff, tos_in;
   logic [CW-1:0]       count_ff, count_in;
   status_type          err_ff, err_in;
   logic [SYM_W-1:0]    sym_ff;
   logic                last_ff;
   logic [DATA_W-1:0]   value_ff, value_in;
   status_type          status_ff, status_in;
   logic [CW-1:0]       wr_count, rd_count;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [DATA_W-1:0]   alu_res;
   logic [DATA_W-1:0]   quotient;
   logic                div_done;
   logic [3:0]          digit;

   // tos_ff holds entry count-1; the memory holds the entries beneath it
   assign wr_count = count_ff - CW'(1);
   assign rd_count = count_ff - CW'(2);
   assign wr_addr  = wr_count[AW-1:0];
   assign rd_addr  = rd_count[AW-1:0];
   assign digit    = 4'(sym_ff - SYM_ZERO);

   always_ff @(posedge clock) begin
      if (cmd.push && count_ff != '0) begin
         mem[wr_addr] <= tos_ff;
      end
      rd_ff <= mem[rd_addr];
   end

   always_comb begin
      case (decode_op(sym_ff))
         OP_ADD:  alu_res = rd_ff + tos_ff;
         OP_SUB:  alu_res = rd_ff - tos_ff;
         OP_MUL:  alu_res = rd_ff * tos_ff;
         default: alu_res = rd_ff;
      endcase
   end

   pee_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (rd_ff),
      .den      (tos_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      tos_in    = tos_ff;
      count_in  = count_ff;
      err_in    = err_ff;
      value_in  = value_ff;
      status_in = status_ff;
      if (cmd.push) begin
         tos_in   = DATA_W'(digit);
         count_in = count_ff + CW'(1);
      end
      if (cmd.alu) begin
         tos_in   = alu_res;
         count_in = count_ff - CW'(1);
      end
      if (cmd.div_write) begin
         tos_in   = quotient;
         count_in = count_ff - CW'(1);
      end
      if (cmd.set_err) begin
         err_in = cmd.err_code;
      end
      if (cmd.emit) begin
         if (err_ff != ST_OK) begin
            value_in  = '0;
            status_in = err_ff;
         end else if (count_ff == '0) begin
            value_in  = '0;
            status_in = ST_EMPTY;
         end else begin
            value_in  = tos_ff;
            status_in = ST_OK;
         end
         count_in = '0;
         err_in   = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         err_ff   <= ST_OK;
      end else begin
         count_ff <= count_in;
         err_ff   <= err_in;
      end
      tos_ff    <= tos_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      if (cmd.latch) begin
         sym_ff  <= req_symbol;
         last_ff <= req_last;
      end
   end

   always_comb begin
      st            = '0;
      st.is_digit   = is_digit(sym_ff);
      st.op         = decode_op(sym_ff);
      st.full       = (count_ff == CW'(STACK_DEPTH));
      st.lt2        = (count_ff < CW'(2));
      st.err_set    = (err_ff != ST_OK);
      st.last       = last_ff;
      st.right_zero = (tos_ff == '0);
      st.div_done   = div_done;
   end

   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;

endmodule

// ===== hdl/pee_ctrl.sv =====
// Evaluator controller: one-hot sequencer that issues datapath commands per
// character beat and owns both handshakes. Depends on pee_pkg.
module pee_ctrl
   import pee_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type st,
   output cmd_type       cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DECODE = 5'b00010,
      S_EXEC   = 5'b00100,
      S_DIV    = 5'b01000,
      S_FIN    = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   state_type next_after;
   logic      rsp_valid_ff, rsp_valid_in;

   // after a character: close the expression on its last beat
   assign next_after = st.last ? S_FIN : S_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            if (st.err_set) begin
               state_in = next_after;
            end else if (st.is_digit) begin
               if (st.full) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_OVER;
               end else begin
                  cmd.push = 1'b1;
               end
               state_in = next_after;
            end else if (st.lt2) begin
               cmd.set_err  = 1'b1;
               cmd.err_code = ST_UNDER;
               state_in     = next_after;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (st.op == OP_DIV) begin
               if (st.right_zero) begin
                  cmd.set_err  = 1'b1;
                  cmd.err_code = ST_DIVZERO;
                  state_in     = next_after;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIV;
               end
            end else begin
               cmd.alu  = 1'b1;
               state_in = next_after;
            end
         end
         S_DIV: begin
            if (st.div_done) begin
               cmd.div_write = 1'b1;
               state_in      = next_after;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !st.full)
      else $error("push issued on a full stack");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      st.div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide state");

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrites an untaken beat");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !st.right_zero)
      else $error("divider started with zero divisor");
`endif

endmodule

// ===== hdl/postfix_expression_evaluator_unit.sv =====
// Postfix expression evaluator, one character per req beat, one rsp beat per expression.
// Every beat is latched, then decoded; + - * also pass an execute state; other operators
// pass it too and then run the radix-2 divider, producing one quotient bit per cycle. A last beat adds a finish state.
// The result register frees req while a rsp beat waits to be taken.
// Synchronous active-high reset empties the stack and clears the error; no clearing pass.
module postfix_expression_evaluator_unit
   import pee_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
)(
   input logic       clock,
   input logic       reset,
   pee_req_if.sink   req_chan,
   pee_rsp_if.source rsp_chan
);

   cmd_type       cmd;
   dp_status_type st;

   pee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   pee_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .st         (st),
      .req_symbol (req_chan.symbol),
      .req_last   (req_chan.last),
      .rsp_value  (rsp_chan.value),
      .rsp_status (rsp_chan.status)
   );

endmodule

// ===== tb/postfix_expression_evaluator_unit_tb.sv =====
// Self-checking bench for postfix_expression_evaluator_unit: character beats in,
// one result beat per expression out, checked against an in-bench stack evaluator.
// Depends on pee_pkg, pee_req_if/pee_rsp_if and the evaluator RTL.
module postfix_expression_evaluator_unit_tb;
   import pee_pkg::*;

   localparam int          DEPTH         = STACK_DEPTH_DEF;
   localparam int unsigned TOTAL_BEATS   = 1700;
   localparam int unsigned HOLD_AT_BEAT  = 500;
   localparam int unsigned HOLD_CYCLES   = 2000;
   localparam int unsigned LIMIT_CYCLES  = 1_000_000;
   localparam int unsigned DRAIN_CYCLES  = 40;
   localparam int unsigned REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      status_type        status;
   } expr_result_type;

   // Tracks the operand stack as characters are taken and queues the result
   // each expression should produce.
   class expr_scoreboard_type;
      logic [DATA_W-1:0] operands[DEPTH];
      int unsigned       depth_used = 0;
      status_type        fault = ST_OK;
      expr_result_type   pending_results[$];
      int unsigned       failures = 0;

      function logic [DATA_W-1:0] quotient_toward_zero(logic [DATA_W-1:0] num,
                                                       logic [DATA_W-1:0] den);
         logic [DATA_W-1:0] mag_n, mag_d, q;
         mag_n = num[DATA_W-1] ? -num : num;
         mag_d = den[DATA_W-1] ? -den : den;
         q     = mag_n / mag_d;
         return (num[DATA_W-1] ^ den[DATA_W-1]) ? -q : q;
      endfunction

      function void note_symbol(logic [SYM_W-1:0] sym, logic is_last);
         logic [DATA_W-1:0] rhs, lhs, folded;
         expr_result_type   outcome;
         folded = '0;
         if (fault == ST_OK) begin
            if (sym >= SYM_ZERO && sym <= SYM_NINE) begin
               if (depth_used >= DEPTH) begin
                  fault = ST_OVER;
               end else begin
                  operands[depth_used] = DATA_W'(sym - SYM_ZERO);
                  depth_used++;
               end
            end else if (depth_used < 2) begin
               fault = ST_UNDER;
            end else begin
               rhs = operands[depth_used-1];
               lhs = operands[depth_used-2];
               depth_used -= 2;
               if (sym == SYM_PLUS) begin
                  folded = lhs + rhs;
               end else if (sym == SYM_MINUS) begin
                  folded = lhs - rhs;
               end else if (sym == SYM_STAR) begin
                  folded = lhs * rhs;
               end else if (rhs == '0) begin
                  fault = ST_DIVZERO;   // operands are gone, nothing pushed
               end else begin
                  folded = quotient_toward_zero(lhs, rhs);
               end
               if (fault == ST_OK) begin
                  operands[depth_used] = folded;
                  depth_used++;
               end
            end
         end
         if (is_last) begin
            outcome.value  = '0;
            outcome.status = fault;
            if (fault == ST_OK) begin
               if (depth_used == 0) outcome.status = ST_EMPTY;
               else                 outcome.value  = operands[depth_used-1];
            end
            pending_results = {pending_results, outcome};
            depth_used = 0;
            fault      = ST_OK;
         end
      endfunction

      function void check_result(logic [DATA_W-1:0] value, logic [STATUS_W-1:0] status);
         expr_result_type want;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR @%0t: unexpected result value=%0d status=%0d",
                        $time, $signed(value), status);
            return;
         end
         want = pending_results.pop_front();
         if (value !== want.value || status !== want.status) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("ERROR @%0t: value exp %0d got %0d, status exp %0d got %0d",
                        $time, $signed(want.value), $signed(value), want.status, status);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   pee_req_if req_chan ();
   pee_rsp_if rsp_chan ();

   postfix_expression_evaluator_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   expr_scoreboard_type board = new;
   int unsigned      beats_taken    = 0;
   int unsigned      send_idle_pct  = 0;
   int unsigned      recv_stall_pct = 0;
   int unsigned      hold_left      = 0;
   bit               hold_done      = 1'b0;
   int unsigned      cycle_count    = 0;
   logic [SYM_W-1:0] formula[$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("postfix_expression_evaluator_unit: mismatch");
         $finish;
      end
   end

   // Result side: random stalls plus one long hold-off so the block backs up.
   always @(posedge clock) begin
      if (!hold_done && beats_taken >= HOLD_AT_BEAT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Inputs only move at rising edges, so the negedge view is what the next edge takes.
   always @(negedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_result(rsp_chan.value, rsp_chan.status);
   end

   function automatic logic [SYM_W-1:0] digit_sym(int unsigned v);
      return SYM_ZERO + SYM_W'(v);
   endfunction

   // Any character that is neither a digit nor + - * divides.
   function automatic logic [SYM_W-1:0] divide_sym();
      logic [SYM_W-1:0] s;
      do s = SYM_W'($urandom_range(255));
      while ((s >= SYM_ZERO && s <= SYM_NINE) || s == SYM_PLUS || s == SYM_MINUS ||
             s == SYM_STAR);
      return s;
   endfunction

   function automatic logic [SYM_W-1:0] pick_operator();
      case ($urandom_range(9))
         0, 1, 2: return SYM_PLUS;
         3, 4:    return SYM_MINUS;
         5, 6, 7: return SYM_STAR;
         default: return divide_sym();
      endcase
   endfunction

   // Well-formed postfix with the given number of operands.
   function automatic void add_formula(int unsigned operand_total);
      int unsigned to_push, held;
      to_push = operand_total;
      held    = 0;
      while (to_push > 0 || held > 1) begin
         if (to_push > 0 && (held < 2 || $urandom_range(1) == 0)) begin
            formula = {formula, digit_sym($urandom_range(9))};
            to_push--;
            held++;
         end else begin
            formula = {formula, pick_operator()};
            held--;
         end
      end
   endfunction

   function automatic void set_phase();
      if (beats_taken < 400) begin
         send_idle_pct = 0;  recv_stall_pct = 0;
      end else if (beats_taken < 800) begin
         send_idle_pct = 54; recv_stall_pct = 0;
      end else if (beats_taken < 1200) begin
         send_idle_pct = 0;  recv_stall_pct = 54;
      end else begin
         send_idle_pct = 18; recv_stall_pct = 18;
      end
   endfunction

   // Starts and ends at a rising edge; valid stays up after the beat so that
   // back-to-back beats never see a drop and re-raise in one step.
   task automatic send_beat(input logic [SYM_W-1:0] sym, input logic is_last);
      bit took;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.symbol <= sym;
      req_chan.last   <= is_last;
      do begin
         @(negedge clock);
         took = req_chan.ready;
         if (took) begin
            board.note_symbol(sym, is_last);
            beats_taken++;
         end
         @(posedge clock);
      end while (!took);
   endtask

   task automatic send_formula();
      foreach (formula[i]) send_beat(formula[i], i == formula.size() - 1);
   endtask

   task automatic send_text(input string s);
      formula.delete();
      for (int i = 0; i < s.len(); i++) formula = {formula, SYM_W'(s[i])};
      send_formula();
   endtask

   initial begin
      int unsigned kind;
      reset           = 1'b1;
      req_chan.valid  = 1'b0;
      req_chan.symbol = '0;
      req_chan.last   = 1'b0;
      rsp_chan.ready  = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: digit extremes, each operator, error cases, leftovers
      send_text("9");
      send_text("0");
      send_text("+");
      send_text("34+");
      send_text("35-");
      send_text("97*");
      send_text("50/");
      formula = '{SYM_ZERO, digit_sym(5), SYM_MINUS, digit_sym(2), 8'hFF};
      send_formula();
      send_text("1+2");
      send_text("123+");

      while (beats_taken < TOTAL_BEATS) begin
         set_phase();
         formula.delete();
         kind = $urandom_range(99);
         if (kind < 68) begin
            add_formula(($urandom_range(9) == 0) ? $urandom_range(1, 24)
                                                 : $urandom_range(1, 8));
         end else if (kind < 78) begin
            // broken: operators may run short, operands may be left over
            repeat ($urandom_range(1, 8))
               formula = {formula, ($urandom_range(1) ? digit_sym($urandom_range(9))
                                                      : pick_operator())};
         end else if (kind < 88) begin
            repeat ($urandom_range(1, 6)) formula = {formula, SYM_W'($urandom_range(255))};
         end else if (kind < 93) begin
            // fill the stack to the brim, then fold part or all of it
            repeat (DEPTH) formula = {formula, digit_sym($urandom_range(9))};
            repeat ($urandom_range(1, DEPTH - 1)) formula = {formula, pick_operator()};
         end else if (kind < 97) begin
            repeat (DEPTH + 1 + $urandom_range(2))
               formula = {formula, digit_sym($urandom_range(9))};
            repeat ($urandom_range(2)) formula = {formula, pick_operator()};
         end else begin
            // 2^31 wraps to the most negative value, then divide by -1
            formula = {formula, digit_sym(2)};
            repeat (30) begin
               formula = {formula, digit_sym(2)};
               formula = {formula, SYM_STAR};
            end
            formula = {formula, digit_sym(0)};
            formula = {formula, digit_sym(1)};
            formula = {formula, SYM_MINUS};
            formula = {formula, divide_sym()};
            if ($urandom_range(1)) begin
               formula = {formula, digit_sym(1)};
               formula = {formula, SYM_MINUS};
            end
         end
         send_formula();
      end
      req_chan.valid <= 1'b0;

      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.failures == 0 && board.pending_results.size() == 0)
         $display("postfix_expression_evaluator_unit: match");
      else
         $display("postfix_expression_evaluator_unit: mismatch");
      $finish;
   end

endmodule
